// ----- hw/rtl/ale_pkg.sv -----
// Shared command codes, status codes and sequencer state type for the array list engine.
package ale_pkg;

  // Command codes carried on the input channel.
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_SPLIT  = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // Status codes returned with every result.
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_RANGE     = 2'd3;

  // Field widths fixed by the interface.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COUNT_W = 7;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    SQ_IDLE      = 9'b000000001,
    SQ_SCAN_RD   = 9'b000000010,
    SQ_SCAN_CMP  = 9'b000000100,
    SQ_SHIFT_RD  = 9'b000001000,
    SQ_SHIFT_WR  = 9'b000010000,
    SQ_COPY_RD   = 9'b000100000,
    SQ_COPY_WR   = 9'b001000000,
    SQ_READ_DATA = 9'b010000000,
    SQ_FINISH    = 9'b100000000
  } seq_state_t;

endpackage

// ----- hw/rtl/array_list_engine_unit.sv -----
// Top level of the array list engine: command sequencer, two key stores and result register.

// The engine keeps a list of signed 32-bit keys in a primary store of CAP entries and a second
// store that receives the tail of a split. It takes one command at a time and holds in_stall
// high until the command has finished and its result sits in the output register; a new
// command may be taken while that result still waits for the consumer. Each store is a
// memory with one write port and one registered read port, and the sequencer walks it entry
// by entry, with a read state and then a compare or write state for each. Clear, append,
// unknown commands and a read out of range go straight to the finish state; a read in range
// passes through a data state first. Find scans from index 0 until the key matches or the
// list ends; remove then shifts each later entry down one place, and split copies the matched
// entry and all after it to the second store. A result that waits in the output register
// holds the next command in its finish state until the consumer takes the result. Stored
// entries are never cleared; only entries below the list lengths are ever used.
module array_list_engine_unit #(
  parameter int unsigned CAP = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_key,
  input  logic               in_list_select,
  input  logic [5:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [5:0]         out_found_index,
  output logic signed [31:0] out_key_out,
  output logic [6:0]         out_primary_count,
  output logic [6:0]         out_second_count
);
  import ale_pkg::*;

  localparam int unsigned AW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CW = $clog2(CAP + 1);

  // Sequencer and list state.
  seq_state_t          state_r, state_nxt;
  logic [CW-1:0]       plen_r, plen_nxt;
  logic [CW-1:0]       slen_r, slen_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       at_r, at_nxt;
  logic [CW-1:0]       idx_inc;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic                sel_r, sel_nxt;

  // Pending result fields, loaded into the output register at the end of a command.
  logic [1:0]          res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [KEY_W-1:0]    res_key_r, res_key_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [COUNT_W-1:0]  out_pcount_r;
  logic [COUNT_W-1:0]  out_scount_r;
  logic                out_free;
  logic                out_load;

  // Memory ports.
  logic [KEY_W-1:0]    pmem [CAP];
  logic [KEY_W-1:0]    smem [CAP];
  logic                p_we, s_we;
  logic [AW-1:0]       p_waddr, s_waddr, p_raddr, s_raddr;
  logic [KEY_W-1:0]    p_wdata, s_wdata;
  logic [KEY_W-1:0]    p_rdata_r, s_rdata_r;

  assign idx_inc  = idx_r + CW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != SQ_IDLE);

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    plen_nxt       = plen_r;
    slen_nxt       = slen_r;
    idx_nxt        = idx_r;
    at_nxt         = at_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    sel_nxt        = sel_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_key_nxt    = res_key_r;
    out_load       = 1'b0;
    p_we           = 1'b0;
    s_we           = 1'b0;
    p_waddr        = idx_r[AW-1:0];
    p_wdata        = p_rdata_r;
    s_waddr        = slen_r[AW-1:0];
    s_wdata        = p_rdata_r;
    p_raddr        = idx_r[AW-1:0];
    s_raddr        = AW'(in_position);

    case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key;
          sel_nxt        = in_list_select;
          res_status_nxt = STS_OK;
          res_idx_nxt    = '0;
          res_key_nxt    = '0;
          idx_nxt        = '0;
          state_nxt      = SQ_FINISH;
          case (in_command)
            CMD_CLEAR: begin
              plen_nxt = '0;
            end
            CMD_APPEND: begin
              if (plen_r >= CW'(CAP)) begin
                res_status_nxt = STS_FULL;
              end else begin
                p_we     = 1'b1;
                p_waddr  = plen_r[AW-1:0];
                p_wdata  = in_key;
                plen_nxt = plen_r + CW'(1);
              end
            end
            CMD_REMOVE, CMD_FIND, CMD_SPLIT: begin
              state_nxt = SQ_SCAN_RD;
            end
            CMD_READ: begin
              // Both stores are read at the position; the select picks one next cycle.
              p_raddr = AW'(in_position);
              if (in_list_select ? (in_position < slen_r) : (in_position < plen_r)) begin
                state_nxt = SQ_READ_DATA;
              end else begin
                res_status_nxt = STS_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Search: issue a read of the next stored entry, or give up past the end.
      SQ_SCAN_RD: begin
        if (idx_r < plen_r) begin
          state_nxt = SQ_SCAN_CMP;
        end else begin
          res_status_nxt = STS_NOT_FOUND;
          state_nxt      = SQ_FINISH;
        end
      end

      SQ_SCAN_CMP: begin
        if (p_rdata_r == key_r) begin
          res_idx_nxt = IDX_W'(idx_r);
          res_key_nxt = p_rdata_r;
          at_nxt      = idx_r;
          case (cmd_r)
            CMD_REMOVE: state_nxt = SQ_SHIFT_RD;
            CMD_SPLIT: begin
              slen_nxt  = '0;
              state_nxt = SQ_COPY_RD;
            end
            default: state_nxt = SQ_FINISH;
          endcase
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = SQ_SCAN_RD;
        end
      end

      // Remove: move each later entry down one place.
      SQ_SHIFT_RD: begin
        p_raddr = idx_inc[AW-1:0];
        if (idx_inc < plen_r) begin
          state_nxt = SQ_SHIFT_WR;
        end else begin
          plen_nxt  = plen_r - CW'(1);
          state_nxt = SQ_FINISH;
        end
      end

      SQ_SHIFT_WR: begin
        p_we      = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = SQ_SHIFT_RD;
      end

      // Split: copy the matched entry and everything after it to the second store.
      SQ_COPY_RD: begin
        if (idx_r < plen_r) begin
          state_nxt = SQ_COPY_WR;
        end else begin
          plen_nxt  = at_r;
          state_nxt = SQ_FINISH;
        end
      end

      SQ_COPY_WR: begin
        s_we      = 1'b1;
        slen_nxt  = slen_r + CW'(1);
        idx_nxt   = idx_inc;
        state_nxt = SQ_COPY_RD;
      end

      SQ_READ_DATA: begin
        res_key_nxt = sel_r ? s_rdata_r : p_rdata_r;
        state_nxt   = SQ_FINISH;
      end

      // Hand the result to the output register once it is free.
      SQ_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = SQ_IDLE;
        end
      end

      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  // Output valid clears on a transfer and sets when a result is loaded.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      plen_r      <= '0;
      slen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      slen_r      <= slen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    at_r         <= at_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    sel_r        <= sel_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_key_r    <= res_key_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_key_r    <= res_key_r;
      out_pcount_r <= COUNT_W'(plen_r);
      out_scount_r <= COUNT_W'(slen_r);
    end
  end

  // Primary key store.
  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= pmem[p_raddr];
  end

  // Second key store.
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata_r <= smem[s_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_index   = out_idx_r;
  assign out_key_out       = out_key_r;
  assign out_primary_count = out_pcount_r;
  assign out_second_count  = out_scount_r;

endmodule
